// File: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared constants, round constant table and controller command types.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned ROUNDS      = 64;

   localparam logic ACTION_ABSORB = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0] word_type;

   // Byte source for the datapath write into the block buffer
   typedef enum logic [1:0] {
      SRC_DATA = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         push;       // write one byte into the buffer
      byte_src_type src;
      logic [2:0]   len_sel;    // length byte, 0 = most significant
      logic         add_len;    // add 8 to the bit length
      logic         load_work;  // copy chain into working words, load schedule
      logic         round;      // run one round
      logic         feed;       // add working words into the chain
      logic         restart;    // reload initial hash, clear length and fill
      logic         snap_len;   // latch the length for padding
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } ctrl_stat_type;

   function automatic word_type initial_hash(input logic [2:0] idx);
      word_type h;
      unique case (idx)
         3'd0: h = 32'h6A09E667;
         3'd1: h = 32'hBB67AE85;
         3'd2: h = 32'h3C6EF372;
         3'd3: h = 32'hA54FF53A;
         3'd4: h = 32'h510E527F;
         3'd5: h = 32'h9B05688C;
         3'd6: h = 32'h1F83D9AB;
         3'd7: h = 32'h5BE0CD19;
         default: h = 32'h0;
      endcase
      return h;
   endfunction

   function automatic word_type round_k(input logic [5:0] t);
      word_type k;
      unique case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// File: hdl/sha256_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, schedule window, working words, chain words and bit length.
// ----------------------------------------------------------------------------
module sha256_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha256_pkg::ctrl_cmd_type cmd,
   input  logic [7:0]               data_byte,
   input  logic [2:0]               out_sel,
   output sha256_pkg::ctrl_stat_type stat,
   output sha256_pkg::word_type     out_word
);
   import sha256_pkg::*;

   logic [7:0]  buf_ff [BLOCK_BYTES];
   word_type    w_ff [16];
   word_type    v_ff [8];
   word_type    h_ff [8];
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  t_ff, t_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] snap_ff;
   logic [7:0]  wbyte;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Select the byte written into the buffer
   always_comb begin
      unique case (cmd.src)
         SRC_DATA: wbyte = data_byte;
         SRC_PAD:  wbyte = PAD_MARK;
         SRC_ZERO: wbyte = 8'h00;
         SRC_LEN:  wbyte = snap_ff[(7 - cmd.len_sel) * 8 +: 8];
         default:  wbyte = 8'h00;
      endcase
   end

   assign fill_in = cmd.push ? fill_ff + 6'd1 : fill_ff;
   assign t_in    = cmd.load_work ? 6'd0 : (cmd.round ? t_ff + 6'd1 : t_ff);
   assign len_in  = cmd.restart ? 64'd0 : (cmd.add_len ? len_ff + 64'd8 : len_ff);

   // Hold control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         t_ff    <= '0;
         len_ff  <= '0;
      end else begin
         fill_ff <= cmd.restart ? 6'd0 : fill_in;
         t_ff    <= t_in;
         len_ff  <= len_in;
      end
   end

   // Latch length and shift bytes into the buffer, oldest byte at entry 0
   always_ff @(posedge clock) begin
      if (cmd.snap_len) snap_ff <= len_ff;
      if (cmd.push) begin
         for (int i = 0; i < BLOCK_BYTES - 1; i++) buf_ff[i] <= buf_ff[i+1];
         buf_ff[BLOCK_BYTES-1] <= wbyte;
      end
   end

   // Round logic
   word_type s0, s1, ch, mj, t1, t2, wt, g0, g1, wnew;
   always_comb begin
      g1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      g0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      wnew = g1 + w_ff[9] + g0 + w_ff[0];
      wt   = w_ff[0];
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6]));
      t1 = v_ff[7] + s1 + ch + round_k(t_ff) + wt;
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) | ((v_ff[0] | v_ff[1]) & v_ff[2]);
      t2 = s0 + mj;
   end

   // Advance schedule window and working words
   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         for (int i = 0; i < 16; i++)
            w_ff[i] <= {buf_ff[4*i], buf_ff[4*i+1], buf_ff[4*i+2], buf_ff[4*i+3]};
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // Chain words
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         if (reset || cmd.restart) h_ff[i] <= initial_hash(3'(i));
         else if (cmd.feed)        h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.round_last = (t_ff == 6'(ROUNDS - 1));
   assign out_word        = h_ff[out_sel];

endmodule

// File: hdl/sha256_control.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      in_action,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [2:0]                out_sel,
   input  sha256_pkg::ctrl_stat_type stat,
   output sha256_pkg::ctrl_cmd_type  cmd
);
   import sha256_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LEN   = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_FEED  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic       fin_ff, fin_in;    // padding in progress
   logic [2:0] cnt_ff, cnt_in;    // length byte or output word index
   logic       done_ff, done_in;  // length bytes written, digest follows
   logic       take;

   assign in_ready  = (state_ff == ST_IDLE);
   assign take      = in_valid && in_ready;
   assign out_valid = (state_ff == ST_OUT);
   assign out_sel   = cnt_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.src  = SRC_DATA;
      cmd.len_sel = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.push = 1'b1;
               if (in_action == ACTION_FINISH) begin
                  cmd.src = SRC_PAD;
                  cmd.snap_len = 1'b1;
                  fin_in = 1'b1;
               end else begin
                  cmd.add_len = 1'b1;
               end
               if (stat.fill == 6'd63) state_in = ST_LOAD;
               else if (in_action == ACTION_FINISH)
                  state_in = (stat.fill == 6'd55) ? ST_LEN : ST_PAD;
               cnt_in = 3'd0;
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_ZERO;
            if (stat.fill == 6'd63) state_in = ST_LOAD;
            else if (stat.fill == 6'd55) state_in = ST_LEN;
         end
         ST_LEN: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN;
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_LOAD;
               fin_in   = 1'b0;
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.round_last) state_in = ST_FEED;
         end
         ST_FEED: begin
            cmd.feed = 1'b1;
            if (fin_ff) state_in = (stat.fill == 6'd56) ? ST_LEN : ST_PAD;
            else if (cnt_ff == 3'd0 && done_ff) state_in = ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (out_ready) begin
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Length bytes done marks a finished message
   assign done_in = (state_ff == ST_LEN && cnt_ff == 3'd7) ? 1'b1 :
                    (state_ff == ST_OUT) ? 1'b0 : done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

endmodule

// File: hdl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Top level: one byte per transaction in, eight digest words out on finish.
// ----------------------------------------------------------------------------
// An absorb transaction writes one byte into the block buffer; every 64th byte
// also starts a compression (a load step, then one round per cycle through the
// single round unit, then a feed step), and no byte is taken until it is done.
// A finish transaction pads byte by byte (pad and length bytes, one or two
// compressions) and then offers the eight digest words, one per cycle while
// rsp_tready is high. No new transaction is taken until the digest is out.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic [2:0]    sel;
   word_type      word;

   sha256_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_action(req_tuser),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_sel(sel),
      .stat(stat), .cmd(cmd)
   );

   sha256_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_byte(req_tdata),
      .out_sel(sel), .stat(stat), .out_word(word)
   );

   assign rsp_tdata = {5'd0, sel, word};
   assign rsp_tlast = (sel == 3'd7);

endmodule

// File: hdl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for input/output exclusion, ordering of digest words and output hold.
// ----------------------------------------------------------------------------
module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   // Never take input while a digest is being offered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken during output");

   // Last flag marks word seven only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last flag mismatch");

   // Word index advances by one after an accepted non-last word
   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1))
      else $error("word index skipped");

   // Stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled output changed");
endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
